FILE: hw/rtl/wsb_pkg.sv
// Shared types and constants for the wheel speed balance controller.
`default_nettype none

package wsb_pkg;

    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned DRIVE_W  = 8;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned SINCE_W  = 5;
    // difference of two signed counts spans +/-(2^32 - 1): two extra bits
    localparam int unsigned DIFF_W   = COUNT_W + 2;
    localparam int unsigned ERR_W    = DIFF_W + 1;
    localparam int unsigned PROD_W   = ERR_W + GAIN_W;
    localparam int unsigned CORR_W   = 7;
    localparam int unsigned SUM_W    = DRIVE_W + 2;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;

    localparam int unsigned CONTROL_PERIOD_MS_DEF = 20;

    localparam int CORR_LIMIT = 50;
    localparam int DRIVE_MAX  = 255;

    // |prod| >= (limit + 1) * 256 means trunc(prod / 256) lies beyond the limit
    localparam logic signed [PROD_W-1:0] PROD_HI = PROD_W'((CORR_LIMIT + 1) * 256);
    localparam logic signed [PROD_W-1:0] PROD_LO = -PROD_HI;
    localparam logic signed [CORR_W-1:0] CORR_MAX = CORR_W'(CORR_LIMIT);
    localparam logic signed [CORR_W-1:0] CORR_MIN = -CORR_MAX;

    localparam logic [DRIVE_W-1:0]       BASE_RESET     = '0;
    localparam logic [COUNT_W-1:0]       DURATION_RESET = '0;
    localparam logic signed [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(128);

    // register index = paddr[3:2]
    localparam logic [1:0] REG_BASE_DRIVE   = 2'd0;
    localparam logic [1:0] REG_RUN_DURATION = 2'd1;
    localparam logic [1:0] REG_BALANCE_GAIN = 2'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [COUNT_W-1:0] left_count;
        logic signed [COUNT_W-1:0] right_count;
    } wsb_req_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] left_drive;
        logic [DRIVE_W-1:0] right_drive;
        logic               clear_encoders;
        logic               busy_res;
        logic               finished;
    } wsb_rsp_t;

    // what the request does to the drive registers
    typedef enum logic [1:0] {
        KIND_HOLD = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_STEP = 2'd2
    } wsb_kind_t;

    typedef struct packed {
        wsb_kind_t kind;
        logic      clear_encoders;
        logic      busy;
        logic      finished;
    } wsb_flags_t;

    typedef struct packed {
        wsb_flags_t               flags;
        logic signed [DIFF_W-1:0] diff_l;
        logic signed [DIFF_W-1:0] diff_r;
    } wsb_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wsb_seq.sv
// Run sequencer: run state, elapsed time, control period and previous counts.
`default_nettype none

module wsb_seq #(
    parameter int unsigned CONTROL_PERIOD_MS = wsb_pkg::CONTROL_PERIOD_MS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  wsb_pkg::wsb_req_t             req,
    input  logic [wsb_pkg::DRIVE_W-1:0]   base_drive,
    input  logic [wsb_pkg::COUNT_W-1:0]   run_duration_ms,
    output wsb_pkg::wsb_op_t              op
);
    import wsb_pkg::*;

    localparam logic [SINCE_W-1:0] PERIOD = SINCE_W'(CONTROL_PERIOD_MS);

    logic                      running_reg, running_next;
    logic [COUNT_W-1:0]        elapsed_reg, elapsed_next;
    logic [SINCE_W-1:0]        since_reg, since_next;
    logic signed [COUNT_W-1:0] prev_left_reg, prev_left_next;
    logic signed [COUNT_W-1:0] prev_right_reg, prev_right_next;
    logic [COUNT_W-1:0]        elapsed_inc;
    logic [SINCE_W-1:0]        since_inc;

    assign elapsed_inc = elapsed_reg + COUNT_W'(1);
    assign since_inc   = since_reg + SINCE_W'(1);

    always_comb
    begin
        // full-precision deltas, only consumed on a control step
        op.diff_l                 = DIFF_W'(req.left_count) - DIFF_W'(prev_left_reg);
        op.diff_r                 = DIFF_W'(req.right_count) - DIFF_W'(prev_right_reg);
        running_next              = running_reg;
        elapsed_next              = elapsed_reg;
        since_next                = since_reg;
        prev_left_next            = prev_left_reg;
        prev_right_next           = prev_right_reg;
        op.flags.kind             = KIND_HOLD;
        op.flags.clear_encoders   = 1'b0;
        op.flags.finished         = 1'b0;

        if (req.command == CMD_START)
        begin
            elapsed_next    = '0;
            since_next      = '0;
            prev_left_next  = '0;
            prev_right_next = '0;
            op.flags.kind   = KIND_ZERO;
            if (base_drive == '0 || run_duration_ms == '0)
            begin
                running_next      = 1'b0;
                op.flags.finished = 1'b1;
            end
            else
            begin
                running_next            = 1'b1;
                op.flags.clear_encoders = 1'b1;
            end
        end
        else if (running_reg)
        begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= run_duration_ms)
            begin
                running_next      = 1'b0;
                op.flags.kind     = KIND_ZERO;
                op.flags.finished = 1'b1;
            end
            else if (since_inc >= PERIOD)
            begin
                since_next      = '0;
                op.flags.kind   = KIND_STEP;
                prev_left_next  = req.left_count;
                prev_right_next = req.right_count;
            end
            else
            begin
                since_next = since_inc;
            end
        end

        op.flags.busy = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            elapsed_reg    <= '0;
            since_reg      <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
        end
        else if (accept)
        begin
            running_reg    <= running_next;
            elapsed_reg    <= elapsed_next;
            since_reg      <= since_next;
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wsb_pipe.sv
// Correction pipeline: abs deltas, error, gain multiply, clamp, drive update.
`default_nettype none

module wsb_pipe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              op_valid,
    input  wsb_pkg::wsb_op_t                  op,
    output logic                              op_ready,
    input  logic [wsb_pkg::DRIVE_W-1:0]       base_drive,
    input  logic signed [wsb_pkg::GAIN_W-1:0] balance_gain,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output wsb_pkg::wsb_rsp_t                 rsp
);
    import wsb_pkg::*;

    function automatic logic [DRIVE_W-1:0] clamp_drive(input logic signed [SUM_W-1:0] sum);
        logic [DRIVE_W-1:0] res;
        if (sum < 0)
            res = '0;
        else if (sum > SUM_W'(DRIVE_MAX))
            res = DRIVE_W'(DRIVE_MAX);
        else
            res = sum[DRIVE_W-1:0];
        return res;
    endfunction

    // stage registers
    logic                      s1_vld_reg;
    wsb_op_t                   s1_reg;
    logic                      s2_vld_reg;
    wsb_flags_t                s2_flags_reg;
    logic [DIFF_W-1:0]         s2_mag_l_reg, s2_mag_r_reg;
    logic                      s3_vld_reg;
    wsb_flags_t                s3_flags_reg;
    logic signed [ERR_W-1:0]   s3_err_reg;
    logic                      s4_vld_reg;
    wsb_flags_t                s4_flags_reg;
    logic signed [PROD_W-1:0]  s4_prod_reg;
    logic                      s5_vld_reg;
    wsb_flags_t                s5_flags_reg;
    logic signed [CORR_W-1:0]  s5_corr_reg;
    logic                      out_vld_reg;
    wsb_flags_t                out_flags_reg;
    logic [DRIVE_W-1:0]        left_reg, right_reg;

    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;

    logic [DIFF_W-1:0]         mag_l_next, mag_r_next;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [CORR_W-1:0]  corr_next;
    logic signed [GAIN_W:0]    trunc_adj;
    logic signed [SUM_W-1:0]   sum_l, sum_r;

    // a stage takes new data when empty or when its contents move on
    assign out_rdy  = !out_vld_reg || rsp_ready;
    assign s5_rdy   = !s5_vld_reg || out_rdy;
    assign s4_rdy   = !s4_vld_reg || s5_rdy;
    assign s3_rdy   = !s3_vld_reg || s4_rdy;
    assign s2_rdy   = !s2_vld_reg || s3_rdy;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign op_ready = s1_rdy;

    assign mag_l_next = s1_reg.diff_l[DIFF_W-1] ? DIFF_W'(-s1_reg.diff_l)
                                                 : DIFF_W'(s1_reg.diff_l);
    assign mag_r_next = s1_reg.diff_r[DIFF_W-1] ? DIFF_W'(-s1_reg.diff_r)
                                                 : DIFF_W'(s1_reg.diff_r);

    assign err_next  = $signed({1'b0, s2_mag_l_reg}) - $signed({1'b0, s2_mag_r_reg});
    assign prod_next = s3_err_reg * balance_gain;

    // divide by 256 toward zero; inside the limit the product fits 16 bits
    assign trunc_adj = (GAIN_W + 1)'($signed(s4_prod_reg[GAIN_W-1:0]))
                     + (s4_prod_reg[PROD_W-1] ? (GAIN_W + 1)'(255) : '0);

    always_comb
    begin
        if (s4_prod_reg >= PROD_HI)
            corr_next = CORR_MAX;
        else if (s4_prod_reg <= PROD_LO)
            corr_next = CORR_MIN;
        else
            corr_next = CORR_W'(trunc_adj >>> 8);
    end

    assign sum_l = $signed({2'b00, base_drive}) - SUM_W'(s5_corr_reg);
    assign sum_r = $signed({2'b00, base_drive}) + SUM_W'(s5_corr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            left_reg    <= '0;
            right_reg   <= '0;
        end
        else
        begin
            if (s1_rdy)
                s1_vld_reg <= op_valid;
            if (s2_rdy)
                s2_vld_reg <= s1_vld_reg;
            if (s3_rdy)
                s3_vld_reg <= s2_vld_reg;
            if (s4_rdy)
                s4_vld_reg <= s3_vld_reg;
            if (s5_rdy)
                s5_vld_reg <= s4_vld_reg;
            if (out_rdy)
            begin
                out_vld_reg <= s5_vld_reg;
                if (s5_vld_reg)
                begin
                    case (s5_flags_reg.kind)
                        KIND_ZERO:
                        begin
                            left_reg  <= '0;
                            right_reg <= '0;
                        end
                        KIND_STEP:
                        begin
                            left_reg  <= clamp_drive(sum_l);
                            right_reg <= clamp_drive(sum_r);
                        end
                        default:
                        begin
                            left_reg  <= left_reg;
                            right_reg <= right_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
            s1_reg <= op;
        if (s2_rdy)
        begin
            s2_flags_reg <= s1_reg.flags;
            s2_mag_l_reg <= mag_l_next;
            s2_mag_r_reg <= mag_r_next;
        end
        if (s3_rdy)
        begin
            s3_flags_reg <= s2_flags_reg;
            s3_err_reg   <= err_next;
        end
        if (s4_rdy)
        begin
            s4_flags_reg <= s3_flags_reg;
            s4_prod_reg  <= prod_next;
        end
        if (s5_rdy)
        begin
            s5_flags_reg <= s4_flags_reg;
            s5_corr_reg  <= corr_next;
        end
        if (out_rdy && s5_vld_reg)
            out_flags_reg <= s5_flags_reg;
    end

    assign rsp_valid          = out_vld_reg;
    assign rsp.left_drive     = left_reg;
    assign rsp.right_drive    = right_reg;
    assign rsp.clear_encoders = out_flags_reg.clear_encoders;
    assign rsp.busy_res       = out_flags_reg.busy;
    assign rsp.finished       = out_flags_reg.finished;

endmodule

`default_nettype wire

FILE: hw/rtl/wheel_speed_balance_controller.sv
// Top level of the wheel speed balance controller: register port and pipeline.
`default_nettype none

// Timed straight-drive controller for two wheels. A start request (command 0)
// arms a run and, if base drive and duration are both nonzero, flags
// clear_encoders; otherwise it ends at once with finished set and drives 0/0.
// Each tick request (command 1) carries both encoder counts. Every
// CONTROL_PERIOD_MS ticks the absolute count deltas of the two wheels are
// compared, the difference is scaled by the signed Q8.8 gain, truncated toward
// zero and clamped to +/-50, then subtracted from the left and added to the
// right base drive, each clamped to 0..255. When the elapsed tick count reaches
// run_duration_ms the drives drop to 0 and finished pulses. Every request gives
// exactly one response. Throughput: one request per clock; the response is
// registered through run state, abs deltas, error, gain multiply, clamp and
// output register, and the pipeline only stalls where a response waits on
// rsp_ready with every stage full. Registers sit at byte
// addresses 0x0 (base_drive), 0x4 (run_duration_ms), 0x8 (balance_gain, signed,
// reset 0x0080 = 0.5); write them only while no request is in flight.
module wheel_speed_balance_controller #(
    parameter int unsigned CONTROL_PERIOD_MS = wsb_pkg::CONTROL_PERIOD_MS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsb_pkg::PADDR_W-1:0]   paddr,
    input  logic [wsb_pkg::PDATA_W-1:0]   pwdata,
    output logic [wsb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // request channel
    input  logic                          req_valid,
    output logic                          req_ready,
    input  wsb_pkg::wsb_req_t             req,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output wsb_pkg::wsb_rsp_t             rsp
);
    import wsb_pkg::*;

    logic [DRIVE_W-1:0]        base_drive_reg;
    logic [COUNT_W-1:0]        duration_reg;
    logic signed [GAIN_W-1:0]  gain_reg;
    logic [1:0]                reg_index;
    logic                      cfg_write;
    logic                      accept;
    wsb_op_t                   op;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_drive_reg <= BASE_RESET;
            duration_reg   <= DURATION_RESET;
            gain_reg       <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_BASE_DRIVE:   base_drive_reg <= pwdata[DRIVE_W-1:0];
                REG_RUN_DURATION: duration_reg   <= pwdata[COUNT_W-1:0];
                REG_BALANCE_GAIN: gain_reg       <= pwdata[GAIN_W-1:0];
                default:          base_drive_reg <= base_drive_reg;
            endcase
        end
    end

    // read back; gain sign-extended to the bus
    always_comb
    begin
        unique case (reg_index)
            REG_BASE_DRIVE:   prdata = PDATA_W'(base_drive_reg);
            REG_RUN_DURATION: prdata = PDATA_W'(duration_reg);
            REG_BALANCE_GAIN: prdata = PDATA_W'(gain_reg);
            default:          prdata = '0;
        endcase
    end

    assign accept = req_valid && req_ready;

    // run state lives at the front so back-to-back ticks see it current
    wsb_seq #(
        .CONTROL_PERIOD_MS (CONTROL_PERIOD_MS)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .req             (req),
        .base_drive      (base_drive_reg),
        .run_duration_ms (duration_reg),
        .op              (op)
    );

    // drive registers live at the back and update in request order
    wsb_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (accept),
        .op           (op),
        .op_ready     (req_ready),
        .base_drive   (base_drive_reg),
        .balance_gain (gain_reg),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/wsb_checker.sv
// Port-level checks for the wheel speed balance controller, bound to the top.
`default_nettype none

module wsb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  wsb_pkg::wsb_rsp_t             rsp
);
    import wsb_pkg::*;

    logic [DRIVE_W-1:0] spread;

    // correction is at most 50 each way, so the drives never part by more than 100
    assign spread = (rsp.left_drive >= rsp.right_drive) ? rsp.left_drive - rsp.right_drive
                                                        : rsp.right_drive - rsp.left_drive;

    a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.finished |->
            rsp.left_drive == '0 && rsp.right_drive == '0 && !rsp.busy_res
            && !rsp.clear_encoders)
        else $error("finished response with drive or busy still set");

    a_clear_starts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.clear_encoders |->
            rsp.busy_res && rsp.left_drive == '0 && rsp.right_drive == '0)
        else $error("encoder clear without a fresh run");

    a_spread: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> spread <= DRIVE_W'(2 * CORR_LIMIT))
        else $error("drive spread beyond twice the correction limit");

    a_idle_drives: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.busy_res |-> rsp.left_drive == '0 && rsp.right_drive == '0)
        else $error("nonzero drive while no run is in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed or dropped");

endmodule

bind wheel_speed_balance_controller wsb_checker u_wsb_checker (.*);

`default_nettype wire

FILE: tb/wsb_drive_checker.sv
// Checker for the wheel speed balance controller: predicts each response and compares it.
`timescale 1ns / 100ps

module wsb_drive_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [wsb_pkg::PADDR_W-1:0] paddr,
    input  logic [wsb_pkg::PDATA_W-1:0] pwdata,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  wsb_pkg::wsb_req_t           req,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  wsb_pkg::wsb_rsp_t           rsp,
    output int                          outstanding,
    output int                          mismatch_count
);
    import wsb_pkg::*;

    // register copies, updated from observed writes
    logic [DRIVE_W-1:0]        cfg_base;
    logic [COUNT_W-1:0]        cfg_duration;
    logic signed [GAIN_W-1:0]  cfg_gain;

    // run state
    logic [COUNT_W-1:0]        elapsed;
    logic [SINCE_W-1:0]        since_step;
    logic signed [COUNT_W-1:0] prev_left;
    logic signed [COUNT_W-1:0] prev_right;
    logic [DRIVE_W-1:0]        left_duty;
    logic [DRIVE_W-1:0]        right_duty;
    logic                      run_active;

    wsb_rsp_t drive_expect_q[$];

    // advance the run state by one request and return the response it yields
    function automatic wsb_rsp_t advance_drive(input wsb_req_t r);
        wsb_rsp_t res;
        longint   dl;
        longint   dr;
        longint   corr;
        longint   lsum;
        longint   rsum;
        res = '0;
        if (r.command == CMD_START) begin
            elapsed    = '0;
            since_step = '0;
            prev_left  = '0;
            prev_right = '0;
            left_duty  = '0;
            right_duty = '0;
            if (cfg_base == 0 || cfg_duration == 0) begin
                run_active   = 1'b0;
                res.finished = 1'b1;
            end else begin
                run_active         = 1'b1;
                res.clear_encoders = 1'b1;
            end
        end else if (run_active) begin
            elapsed = elapsed + 1'b1;
            if (elapsed >= cfg_duration) begin
                run_active   = 1'b0;
                left_duty    = '0;
                right_duty   = '0;
                res.finished = 1'b1;
            end else begin
                since_step = since_step + 1'b1;
                if (since_step >= CONTROL_PERIOD_MS_DEF) begin
                    since_step = '0;
                    dl = longint'($signed(r.left_count)) - longint'(prev_left);
                    dr = longint'($signed(r.right_count)) - longint'(prev_right);
                    if (dl < 0) dl = -dl;
                    if (dr < 0) dr = -dr;
                    // Q8.8 gain, quotient truncates toward zero
                    corr = ((dl - dr) * longint'(cfg_gain)) / 256;
                    if (corr > CORR_LIMIT) corr = CORR_LIMIT;
                    if (corr < -CORR_LIMIT) corr = -CORR_LIMIT;
                    lsum = longint'(cfg_base) - corr;
                    rsum = longint'(cfg_base) + corr;
                    if (lsum < 0) lsum = 0;
                    if (lsum > DRIVE_MAX) lsum = DRIVE_MAX;
                    if (rsum < 0) rsum = 0;
                    if (rsum > DRIVE_MAX) rsum = DRIVE_MAX;
                    left_duty  = lsum[DRIVE_W-1:0];
                    right_duty = rsum[DRIVE_W-1:0];
                    prev_left  = r.left_count;
                    prev_right = r.right_count;
                end
            end
        end
        res.left_drive  = left_duty;
        res.right_drive = right_duty;
        res.busy_res    = run_active;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        wsb_rsp_t want;
        if (!rst_n) begin
            cfg_base       = BASE_RESET;
            cfg_duration   = DURATION_RESET;
            cfg_gain       = GAIN_RESET;
            elapsed        = '0;
            since_step     = '0;
            prev_left      = '0;
            prev_right     = '0;
            left_duty      = '0;
            right_duty     = '0;
            run_active     = 1'b0;
            drive_expect_q.delete();
            outstanding    = 0;
            mismatch_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_BASE_DRIVE:   cfg_base     = pwdata[DRIVE_W-1:0];
                    REG_RUN_DURATION: cfg_duration = pwdata[COUNT_W-1:0];
                    REG_BALANCE_GAIN: cfg_gain     = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready) begin
                if (drive_expect_q.size() == 0) begin
                    $error("response %h with no request pending", rsp);
                    mismatch_count++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (rsp.left_drive !== want.left_drive) begin
                        $error("left_drive: expected %0d, got %0d",
                               want.left_drive, rsp.left_drive);
                        mismatch_count++;
                    end
                    if (rsp.right_drive !== want.right_drive) begin
                        $error("right_drive: expected %0d, got %0d",
                               want.right_drive, rsp.right_drive);
                        mismatch_count++;
                    end
                    if (rsp.clear_encoders !== want.clear_encoders) begin
                        $error("clear_encoders: expected %0d, got %0d",
                               want.clear_encoders, rsp.clear_encoders);
                        mismatch_count++;
                    end
                    if (rsp.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d, got %0d",
                               want.busy_res, rsp.busy_res);
                        mismatch_count++;
                    end
                    if (rsp.finished !== want.finished) begin
                        $error("finished: expected %0d, got %0d",
                               want.finished, rsp.finished);
                        mismatch_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                drive_expect_q.push_back(advance_drive(req));
            outstanding = drive_expect_q.size();
        end
    end

endmodule

FILE: tb/tb_wheel_speed_balance_controller.sv
// Testbench top for the wheel speed balance controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_wheel_speed_balance_controller;
    import wsb_pkg::*;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 10;   // longer than the pipeline

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                req_valid;
    logic                req_ready;
    wsb_req_t            req;
    logic                rsp_valid;
    logic                rsp_ready;
    wsb_rsp_t            rsp;

    int                  outstanding;
    int                  mismatch_count;
    int                  idle_cycles;
    int                  burst_left;
    int                  ready_mode;
    int                  ready_cycle;
    int                  random_items;

    // stimulus-side view: what was last written, and the encoders being modeled
    logic [DRIVE_W-1:0]  cur_base;
    logic [COUNT_W-1:0]  cur_duration;
    logic [COUNT_W-1:0]  enc_left;
    logic [COUNT_W-1:0]  enc_right;

    wheel_speed_balance_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    wsb_drive_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Response side back-pressure. A stall style is picked at random, one of:
    // always ready, coin flip, mostly stalled, or a fixed two-in-three rhythm.
    always @(negedge clk)
    begin
        if (ready_cycle % 50 == 0)
            ready_mode = $urandom_range(0, 3);
        ready_cycle++;
        case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (ready_cycle % 3 != 0);
        endcase
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (psel && penable && pwrite && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Send one request. The sender runs in bursts; between bursts valid drops
    // for a random gap (or not at all, so back-to-back stretches happen too).
    // Valid is left high on return so the next request can follow directly.
    // Called and returns on a falling edge.
    task automatic send_request(input logic command, input logic [COUNT_W-1:0] lcount,
                                input logic [COUNT_W-1:0] rcount);
        wsb_req_t item;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        burst_left--;
        item.command     = command;
        item.left_count  = lcount;
        item.right_count = rcount;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    // Start request: counts are don't-care, so they carry random content.
    task automatic send_start();
        send_request(CMD_START, $urandom, $urandom);
        enc_left  = '0;
        enc_right = '0;
    endtask

    // Tick request with encoder counts that mostly creep forward, sometimes
    // jump backward or far, and now and then take fully random values.
    task automatic send_tick();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
        begin
            enc_left  = $urandom;
            enc_right = $urandom;
        end
        else if (sel < 10)
        begin
            enc_left  = enc_left - $urandom_range(0, 60);
            enc_right = enc_right + $urandom_range(0, 3000);
        end
        else
        begin
            enc_left  = enc_left + $urandom_range(0, 30);
            enc_right = enc_right + $urandom_range(0, 30);
        end
        send_request(CMD_TICK, enc_left, enc_right);
    endtask

    // Hold off new requests until every response has come back.
    task automatic drain();
        req_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    // Register write: setup cycle, access cycle, then an idle cycle so psel
    // never drops and rises in the same step.
    task automatic write_reg(input logic [1:0] index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_base(input logic [DRIVE_W-1:0] value);
        write_reg(REG_BASE_DRIVE, {{(PDATA_W-DRIVE_W){1'b0}}, value});
        cur_base = value;
    endtask

    task automatic set_duration(input logic [COUNT_W-1:0] value);
        write_reg(REG_RUN_DURATION, value);
        cur_duration = value;
    endtask

    task automatic set_gain(input logic signed [GAIN_W-1:0] value);
        write_reg(REG_BALANCE_GAIN, {{(PDATA_W-GAIN_W){value[GAIN_W-1]}}, value});
    endtask

    // Between phases: drain, then rewrite a random subset of the registers.
    // Extremes come up often; durations are mostly short so runs finish.
    task automatic pick_config();
        int sel;
        drain();
        if ($urandom_range(0, 2) != 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 6)       set_base('0);
            else if (sel < 16) set_base(8'd255);
            else if (sel < 20) set_base(8'd1);
            else               set_base(DRIVE_W'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)       set_duration('0);
            else if (sel < 10) set_duration('1);
            else if (sel < 20) set_duration($urandom_range(1, 3));
            else               set_duration($urandom_range(15, 150));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)       set_gain(16'sh8000);
            else if (sel < 16) set_gain(16'sh7fff);
            else if (sel < 20) set_gain('0);
            else if (sel < 30) set_gain(GAIN_W'($urandom));
            else               set_gain(GAIN_W'($urandom_range(0, 2048) - 1024));
        end
    endtask

    initial
    begin
        int n_ticks;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_ready    = 1'b0;
        idle_cycles  = 0;
        burst_left   = 0;
        ready_mode   = 0;
        ready_cycle  = 0;
        random_items = 0;
        cur_base     = BASE_RESET;
        cur_duration = DURATION_RESET;
        enc_left     = '0;
        enc_right    = '0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed part ---
        // reset config has base 0: a tick while idle is ignored, a start ends at once
        send_request(CMD_TICK, 32'h8000_0000, 32'h7fff_ffff);
        send_start();

        // nonzero base but zero duration: still ends at once
        drain();
        set_base(8'd255);
        send_start();

        // three-tick run ending on the third tick, then an idle tick;
        // after that a start while running restarts the run
        drain();
        set_duration(32'd3);
        set_gain(16'sh7fff);
        send_start();
        repeat (4) send_tick();
        send_start();
        send_tick();
        send_start();

        // long run with the most negative gain; the first control step sees
        // counts at both extremes. The sender pauses midway until all
        // responses are back.
        drain();
        set_base(8'd128);
        set_duration(32'hffff_ffff);
        set_gain(16'sh8000);
        send_start();
        for (int k = 1; k < CONTROL_PERIOD_MS_DEF; k++)
        begin
            if (k == 10)
                drain();
            send_request(CMD_TICK, $urandom, $urandom);
        end
        send_request(CMD_TICK, 32'h7fff_ffff, 32'h8000_0000);
        send_request(CMD_TICK, 32'h0000_0000, 32'hffff_ffff);

        // --- random part ---
        // Each phase: new config, usually a fresh start (sometimes the run
        // carries on under the new config), then enough ticks to reach the
        // end of the run, with an occasional stray start or a full pause.
        while (random_items < RANDOM_ITEMS)
        begin
            pick_config();
            if ($urandom_range(0, 99) < 85)
            begin
                send_start();
                random_items++;
            end
            if (cur_base == 0 || cur_duration == 0)
                n_ticks = $urandom_range(1, 4);
            else if (cur_duration > 200)
                n_ticks = $urandom_range(40, 200);
            else
                n_ticks = cur_duration + $urandom_range(0, 2);
            for (int k = 1; k <= n_ticks; k++)
            begin
                if ($urandom_range(0, 99) < 2)
                    send_start();
                if ($urandom_range(0, 199) == 0)
                    drain();
                send_tick();
                if (k <= cur_duration)
                    random_items++;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
